// ----- rtl/ppi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants of the plane-plane intersection pipeline.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int unsigned CoefW     = 16;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned DiffW     = 33;
  localparam int unsigned MagW      = 32;
  localparam int unsigned SqW       = 64;
  localparam int unsigned PointW    = 32;
  localparam int unsigned DirW      = 16;

  // point divider: quotient bits and left shift of the numerator
  localparam int unsigned PointBits = 33;
  localparam int unsigned PointFrac = 17;
  // unit direction: divider bits, then square root bits
  localparam int unsigned UnitBits  = 31;
  localparam int unsigned RootBits  = 16;
  localparam int unsigned NumIter   = UnitBits + RootBits;

  localparam logic [31:0] LimitReset = 32'd18;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic signed [ProdW-1:0] b1c2;
    logic signed [ProdW-1:0] c1b2;
    logic signed [ProdW-1:0] c1a2;
    logic signed [ProdW-1:0] a1c2;
    logic signed [ProdW-1:0] a1b2;
    logic signed [ProdW-1:0] b1a2;
    logic signed [ProdW-1:0] c1d2;
    logic signed [ProdW-1:0] c2d1;
    logic signed [ProdW-1:0] b2d1;
    logic signed [ProdW-1:0] b1d2;
    logic signed [ProdW-1:0] a1d2;
    logic signed [ProdW-1:0] a2d1;
  } prod_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dir0;
    logic signed [DiffW-1:0] dir1;
    logic signed [DiffW-1:0] dir2;
    logic signed [DiffW-1:0] nu;
    logic signed [DiffW-1:0] nv;
    logic signed [DiffW-1:0] nw;
  } diff_t;

  typedef struct packed {
    logic [2:0][MagW-1:0] dmag;
    logic [2:0]           dneg;
    axis_e                axis;
    logic [MagW-1:0]      den;
    logic [MagW-1:0]      pa_num;
    logic [MagW-1:0]      pb_num;
    logic                 pa_neg;
    logic                 pb_neg;
    logic [2:0][SqW-1:0]  sq;
  } front_t;

  typedef struct packed {
    logic                      hit;
    axis_e                     axis;
    logic [2:0]                dneg;
    logic [MagW-1:0]           den;
    logic [MagW-1:0]           pa_num;
    logic [MagW-1:0]           pb_num;
    logic                      pa_neg;
    logic                      pb_neg;
    logic                      pa_ovf;
    logic                      pb_ovf;
    logic [MagW-1:0]           pa_rem;
    logic [MagW-1:0]           pb_rem;
    logic [PointBits-1:0]      pa_quo;
    logic [PointBits-1:0]      pb_quo;
    logic [SqW-1:0]            s;
    logic [2:0][SqW-1:0]       urem;
    logic [2:0]                ubit;
    logic [2:0][UnitBits-1:0]  uquo;
    logic [2:0][19:0]          srem;
    logic [2:0][RootBits-1:0]  sroot;
  } iter_t;

endpackage

// ----- rtl/plane_plane_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_plane_intersection
// Line common to two planes: point in Q16.16 and unit direction in Q1.14.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+---------------------------
//  cfg     | cfg_we_i, cfg_data_i             | in        | parallel limit, 32 bit
//  in      | in_valid_i, in_stall_o, *_i      | in        | two planes, 8 x Q4.11
//  out     | out_valid_o, out_stall_i, *_o    | out       | hit, point, unit direction
//
// One word enters per cycle while in_stall_o is low. The pipeline depth is
// set by the unit-direction path: a 31-stage restoring divider
// (|D_i|^2 * 2^30 / |D|^2) followed by a 16-stage integer square root.
// Reset clears all stage valid bits and loads the parallel limit with 18.
// A stall holds only the stages that are full up to the output; bubbles
// ahead of a stalled word keep closing, so the input is stalled only when
// the whole pipeline is full.
// ----------------------------------------------------------------------------
module plane_plane_intersection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] first_a_i,
  input  logic signed [15:0] first_b_i,
  input  logic signed [15:0] first_c_i,
  input  logic signed [15:0] first_d_i,
  input  logic signed [15:0] second_a_i,
  input  logic signed [15:0] second_b_i,
  input  logic signed [15:0] second_c_i,
  input  logic signed [15:0] second_d_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic signed [15:0] dir_x_o,
  output logic signed [15:0] dir_y_o,
  output logic signed [15:0] dir_z_o
);

  localparam int unsigned FrontStages = 4;
  localparam int unsigned NumIter     = ppi_pkg::NumIter;
  localparam int unsigned NumStages   = FrontStages + NumIter + 2;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [ppi_pkg::ProdW-1:0] mul16(
    logic signed [ppi_pkg::CoefW-1:0] a,
    logic signed [ppi_pkg::CoefW-1:0] b
  );
    logic signed [ppi_pkg::ProdW-1:0] ae;
    logic signed [ppi_pkg::ProdW-1:0] be;
    ae = ppi_pkg::ProdW'(a);
    be = ppi_pkg::ProdW'(b);
    mul16 = ae * be;
  endfunction

  function automatic logic signed [ppi_pkg::DiffW-1:0] sub32(
    logic signed [ppi_pkg::ProdW-1:0] a,
    logic signed [ppi_pkg::ProdW-1:0] b
  );
    sub32 = ppi_pkg::DiffW'(a) - ppi_pkg::DiffW'(b);
  endfunction

  function automatic logic [ppi_pkg::MagW-1:0] mag33(logic [ppi_pkg::DiffW-1:0] x);
    logic [ppi_pkg::DiffW-1:0] t;
    t = x[ppi_pkg::DiffW-1] ? (ppi_pkg::DiffW'(0) - x) : x;
    mag33 = t[ppi_pkg::MagW-1:0];
  endfunction

  // One stage of work: a quotient bit of each point divider while those bits
  // last, then either a quotient bit of each unit divider or a root bit of each square root.
  function automatic ppi_pkg::iter_t step_f(ppi_pkg::iter_t cur, int unsigned j);
    ppi_pkg::iter_t nxt;
    logic [ppi_pkg::MagW+ppi_pkg::PointFrac-1:0] nwa;
    logic [ppi_pkg::MagW+ppi_pkg::PointFrac-1:0] nwb;
    logic [ppi_pkg::MagW:0]  ra;
    logic [ppi_pkg::MagW:0]  rb;
    logic [ppi_pkg::MagW:0]  dn;
    logic                    ga;
    logic                    gb;
    logic [ppi_pkg::SqW:0]   ru;
    logic [ppi_pkg::SqW:0]   sd;
    logic                    gu;
    logic [ppi_pkg::UnitBits:0] fw;
    logic [19:0]             rs;
    logic [19:0]             ts;
    logic                    gs;
    int unsigned             ip;
    int unsigned             k;
    int unsigned             c;
    nxt = cur;
    if (j < ppi_pkg::PointBits) begin
      ip  = ppi_pkg::PointBits - 1 - j;
      nwa = {cur.pa_num, ppi_pkg::PointFrac'(0)};
      nwb = {cur.pb_num, ppi_pkg::PointFrac'(0)};
      dn  = {1'b0, cur.den};
      ra  = {cur.pa_rem, nwa[ip]};
      rb  = {cur.pb_rem, nwb[ip]};
      ga  = (ra >= dn);
      gb  = (rb >= dn);
      if (ga) begin
        ra = ra - dn;
      end
      if (gb) begin
        rb = rb - dn;
      end
      nxt.pa_rem = ra[ppi_pkg::MagW-1:0];
      nxt.pb_rem = rb[ppi_pkg::MagW-1:0];
      nxt.pa_quo = {cur.pa_quo[ppi_pkg::PointBits-2:0], ga};
      nxt.pb_quo = {cur.pb_quo[ppi_pkg::PointBits-2:0], gb};
    end
    sd = {1'b0, cur.s};
    for (c = 0; c < 3; c++) begin
      if (j < ppi_pkg::UnitBits) begin
        ru = {cur.urem[c], (j == 0) ? cur.ubit[c] : 1'b0};
        gu = (ru >= sd);
        if (gu) begin
          ru = ru - sd;
        end
        nxt.urem[c] = ru[ppi_pkg::SqW-1:0];
        nxt.uquo[c] = {cur.uquo[c][ppi_pkg::UnitBits-2:0], gu};
      end else begin
        k  = ppi_pkg::NumIter - 1 - j;
        fw = {1'b0, cur.uquo[c]};
        rs = {cur.srem[c][17:0], fw[2*k+1], fw[2*k]};
        ts = {2'b00, cur.sroot[c], 2'b01};
        gs = (rs >= ts);
        if (gs) begin
          rs = rs - ts;
        end
        nxt.srem[c]  = rs;
        nxt.sroot[c] = {cur.sroot[c][ppi_pkg::RootBits-2:0], gs};
      end
    end
    step_f = nxt;
  endfunction

  // Round the doubled quotient half away from zero, saturate, apply sign.
  function automatic logic [ppi_pkg::PointW-1:0] pt_f(
    logic [ppi_pkg::PointBits-1:0] quo,
    logic                          ovf,
    logic                          neg
  );
    logic [ppi_pkg::PointBits:0] q;
    logic [ppi_pkg::PointBits:0] nq;
    q = ({1'b0, quo} + (ppi_pkg::PointBits+1)'(1)) >> 1;
    if (neg) begin
      if (ovf || (q > (ppi_pkg::PointBits+1)'(34'h080000000))) begin
        q = (ppi_pkg::PointBits+1)'(34'h080000000);
      end
      nq   = (ppi_pkg::PointBits+1)'(0) - q;
      pt_f = nq[ppi_pkg::PointW-1:0];
    end else begin
      if (ovf || (q > (ppi_pkg::PointBits+1)'(34'h07FFFFFFF))) begin
        q = (ppi_pkg::PointBits+1)'(34'h07FFFFFFF);
      end
      pt_f = q[ppi_pkg::PointW-1:0];
    end
  endfunction

  function automatic logic [ppi_pkg::DirW-1:0] unit_f(
    logic [ppi_pkg::RootBits-1:0] root,
    logic                         neg
  );
    logic [ppi_pkg::RootBits:0] cr;
    cr = ({1'b0, root} + (ppi_pkg::RootBits+1)'(1)) >> 1;
    unit_f = neg ? (ppi_pkg::DirW'(0) - cr[ppi_pkg::DirW-1:0]) : cr[ppi_pkg::DirW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [31:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ppi_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or the next one advances
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = (adv & {vld_q[NumStages-2:0], in_valid_i}) | (~adv & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  // --------------------------------------------------------------------------
  // Stage 1: the twelve coefficient products
  // --------------------------------------------------------------------------
  ppi_pkg::prod_t prod_q;
  ppi_pkg::prod_t prod_d;

  always_comb begin
    prod_d.b1c2 = mul16(first_b_i, second_c_i);
    prod_d.c1b2 = mul16(first_c_i, second_b_i);
    prod_d.c1a2 = mul16(first_c_i, second_a_i);
    prod_d.a1c2 = mul16(first_a_i, second_c_i);
    prod_d.a1b2 = mul16(first_a_i, second_b_i);
    prod_d.b1a2 = mul16(first_b_i, second_a_i);
    prod_d.c1d2 = mul16(first_c_i, second_d_i);
    prod_d.c2d1 = mul16(second_c_i, first_d_i);
    prod_d.b2d1 = mul16(second_b_i, first_d_i);
    prod_d.b1d2 = mul16(first_b_i, second_d_i);
    prod_d.a1d2 = mul16(first_a_i, second_d_i);
    prod_d.a2d1 = mul16(second_a_i, first_d_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: direction D = n1 x n2 and the three numerator differences
  // --------------------------------------------------------------------------
  ppi_pkg::diff_t diff_q;
  ppi_pkg::diff_t diff_d;

  always_comb begin
    diff_d.dir0 = sub32(prod_q.b1c2, prod_q.c1b2);
    diff_d.dir1 = sub32(prod_q.c1a2, prod_q.a1c2);
    diff_d.dir2 = sub32(prod_q.a1b2, prod_q.b1a2);
    diff_d.nu   = sub32(prod_q.c1d2, prod_q.c2d1);
    diff_d.nv   = sub32(prod_q.b2d1, prod_q.b1d2);
    diff_d.nw   = sub32(prod_q.a1d2, prod_q.a2d1);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      diff_q <= diff_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitudes, dominant axis, numerators and divisor of the point
  // --------------------------------------------------------------------------
  ppi_pkg::front_t sel_q;
  ppi_pkg::front_t sel_d;

  always_comb begin
    logic [ppi_pkg::MagW-1:0]  best;
    logic [ppi_pkg::DiffW-1:0] na;
    logic [ppi_pkg::DiffW-1:0] nb;
    logic                      fa;
    logic                      fb;
    logic                      dsg;
    sel_d         = '0;
    sel_d.dmag[0] = mag33(diff_q.dir0);
    sel_d.dmag[1] = mag33(diff_q.dir1);
    sel_d.dmag[2] = mag33(diff_q.dir2);
    sel_d.dneg    = {diff_q.dir2[ppi_pkg::DiffW-1], diff_q.dir1[ppi_pkg::DiffW-1],
                     diff_q.dir0[ppi_pkg::DiffW-1]};
    // first axis wins ties
    best       = sel_d.dmag[0];
    sel_d.axis = ppi_pkg::AXIS_X;
    if (sel_d.dmag[1] > best) begin
      best       = sel_d.dmag[1];
      sel_d.axis = ppi_pkg::AXIS_Y;
    end
    if (sel_d.dmag[2] > best) begin
      sel_d.axis = ppi_pkg::AXIS_Z;
    end
    // lane A and lane B numerators per axis, with a sign flip where needed
    case (sel_d.axis)
      ppi_pkg::AXIS_Y: begin
        na = diff_q.nu; fa = 1'b1;
        nb = diff_q.nw; fb = 1'b0;
        sel_d.den = sel_d.dmag[1];
        dsg = sel_d.dneg[1];
      end
      ppi_pkg::AXIS_Z: begin
        na = diff_q.nv; fa = 1'b1;
        nb = diff_q.nw; fb = 1'b1;
        sel_d.den = sel_d.dmag[2];
        dsg = sel_d.dneg[2];
      end
      default: begin
        na = diff_q.nu; fa = 1'b0;
        nb = diff_q.nv; fb = 1'b0;
        sel_d.den = sel_d.dmag[0];
        dsg = sel_d.dneg[0];
      end
    endcase
    sel_d.pa_num = mag33(na);
    sel_d.pb_num = mag33(nb);
    sel_d.pa_neg = na[ppi_pkg::DiffW-1] ^ fa ^ dsg;
    sel_d.pb_neg = nb[ppi_pkg::DiffW-1] ^ fb ^ dsg;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sel_q <= sel_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squares of the direction components
  // --------------------------------------------------------------------------
  ppi_pkg::front_t sqr_q;
  ppi_pkg::front_t sqr_d;

  always_comb begin
    sqr_d = sel_q;
    for (int c = 0; c < 3; c++) begin
      sqr_d.sq[c] = ppi_pkg::SqW'(sel_q.dmag[c]) * ppi_pkg::SqW'(sel_q.dmag[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sqr_q <= sqr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: |D|^2, parallel test, divider and root setup
  // --------------------------------------------------------------------------
  ppi_pkg::iter_t it_q [NumIter+1];
  ppi_pkg::iter_t it0_d;
  ppi_pkg::iter_t it_d [1:NumIter];

  always_comb begin
    it0_d        = '0;
    it0_d.s      = sqr_q.sq[0] + sqr_q.sq[1] + sqr_q.sq[2];
    it0_d.hit    = (it0_d.s >= ppi_pkg::SqW'(limit_q)) && (it0_d.s != '0);
    it0_d.axis   = sqr_q.axis;
    it0_d.dneg   = sqr_q.dneg;
    it0_d.den    = sqr_q.den;
    it0_d.pa_num = sqr_q.pa_num;
    it0_d.pb_num = sqr_q.pb_num;
    it0_d.pa_neg = sqr_q.pa_neg;
    it0_d.pb_neg = sqr_q.pb_neg;
    // the top 16 bits of num * 2^17 already reach the divisor: saturate
    it0_d.pa_rem = sqr_q.pa_num >> 16;
    it0_d.pb_rem = sqr_q.pb_num >> 16;
    it0_d.pa_ovf = (it0_d.pa_rem >= sqr_q.den);
    it0_d.pb_ovf = (it0_d.pb_rem >= sqr_q.den);
    for (int c = 0; c < 3; c++) begin
      it0_d.urem[c] = sqr_q.sq[c] >> 1;
      it0_d.ubit[c] = sqr_q.sq[c][0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[FrontStages]) begin
      it_q[0] <= it0_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6 to 52: one divider or root bit per stage
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < NumIter; j++) begin : g_iter
    always_comb begin
      it_d[j+1] = step_f(it_q[j], j);
    end

    always_ff @(posedge clk_i) begin
      if (adv[FrontStages+j+1]) begin
        it_q[j+1] <= it_d[j+1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 53: rounding, saturation, axis mapping; zero point and direction on a miss
  // --------------------------------------------------------------------------
  logic                      hit_q,  hit_d;
  logic [ppi_pkg::PointW-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [ppi_pkg::DirW-1:0]   ux_q, ux_d, uy_q, uy_d, uz_q, uz_d;

  always_comb begin
    logic [ppi_pkg::PointW-1:0] pa;
    logic [ppi_pkg::PointW-1:0] pb;
    ppi_pkg::iter_t             fin;
    fin   = it_q[NumIter];
    pa    = pt_f(fin.pa_quo, fin.pa_ovf, fin.pa_neg);
    pb    = pt_f(fin.pb_quo, fin.pb_ovf, fin.pb_neg);
    hit_d = fin.hit;
    case (fin.axis)
      ppi_pkg::AXIS_Y: begin
        px_d = pa; py_d = '0; pz_d = pb;
      end
      ppi_pkg::AXIS_Z: begin
        px_d = pa; py_d = pb; pz_d = '0;
      end
      default: begin
        px_d = '0; py_d = pa; pz_d = pb;
      end
    endcase
    ux_d = unit_f(fin.sroot[0], fin.dneg[0]);
    uy_d = unit_f(fin.sroot[1], fin.dneg[1]);
    uz_d = unit_f(fin.sroot[2], fin.dneg[2]);
    if (!fin.hit) begin
      px_d = '0; py_d = '0; pz_d = '0;
      ux_d = '0; uy_d = '0; uz_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NumStages-1]) begin
      hit_q <= hit_d;
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
      ux_q  <= ux_d;
      uy_q  <= uy_d;
      uz_q  <= uz_d;
    end
  end

  assign hit_o     = hit_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = pz_q;
  assign dir_x_o   = ux_q;
  assign dir_y_o   = uy_q;
  assign dir_z_o   = uz_q;

endmodule
